FILE: src/teq_pkg.sv
// Types and codes shared by the timed event queue.
package teq_pkg;

	localparam int TIME_W = 32;
	localparam int IN_ID_W = 16;

	typedef enum logic [2:0] {
		CMD_ADD      = 3'd0,
		CMD_LIST_ADD = 3'd1,
		CMD_REMOVE   = 3'd2,
		CMD_ADVANCE  = 3'd3,
		CMD_DUMP_AT  = 3'd4,
		CMD_DUMP_ALL = 3'd5
	} teq_cmd_t;

	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_EVENT = 2'd1,
		KIND_FULL  = 2'd2
	} teq_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_EV,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_FINISH
	} teq_state_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [TIME_W-1:0]  event_time;
		logic [IN_ID_W-1:0] event_id;
		logic [TIME_W-1:0]  time_value;
		logic               last_of_list;
	} teq_in_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [TIME_W-1:0]  out_time;
		logic [IN_ID_W-1:0] out_id;
		logic               last;
	} teq_out_t;

endpackage

FILE: src/timed_event_queue_unit.sv
// Timed event queue: sorted event table with current time, one sequencer over one memory.
//
//  channel | ports              | handshake
//  --------+--------------------+--------------------------------------------
//  command | start, busy, item  | item taken at an edge with start=1, busy=0
//  result  | res_stb, res       | one cycle per result, res.last on the final
//
// Each entry takes a memory read, then a compare and write back, on the
// single registered read port. Insert shifts entries up from the end until the
// item's slot is found; remove, advance and dump scan every entry; list add with
// purge runs both passes. The final result goes out in the finish state. Reset
// clears the count and the current time; the table needs no clearing.
// The receiver cannot stall; busy stays high until the final result has gone out.
module timed_event_queue_unit #(
	parameter int DEPTH = 16,
	parameter int ID_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  teq_pkg::teq_in_t item,
	output logic             res_stb,
	output teq_pkg::teq_out_t res
);
	import teq_pkg::*;

	localparam int ID_W = (ID_BITS < IN_ID_W) ? ID_BITS : IN_ID_W;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [TIME_W-1:0] mem_time [DEPTH];
	logic [ID_W-1:0]   mem_id   [DEPTH];

	teq_state_t state_q, state_d;

	logic [2:0]        cmd_q;
	logic [TIME_W-1:0] et_q;
	logic [ID_W-1:0]   eid_q;
	logic              lastl_q;
	logic [TIME_W-1:0] lim_q;
	logic [TIME_W-1:0] now_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     r_q;
	logic [CW-1:0]     w_q;
	teq_out_t          pend_q;
	logic              pend_vld_q;
	logic [TIME_W-1:0] rd_time_q;
	logic [ID_W-1:0]   rd_id_q;

	logic              accept;
	logic [TIME_W:0]   adv_sum;
	logic [TIME_W-1:0] adv_end;
	logic              ins_ok;
	logic              full;
	logic              post_purge;
	logic [CW-1:0]     idx_m1;
	logic              ins_move;
	logic              compacts;
	logic              t_le;
	logic              t_eq;
	logic              scan_drop;
	logic              scan_emit;
	logic              scan_end;

	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [TIME_W-1:0] mem_wt;
	logic [ID_W-1:0]   mem_wid;
	logic [AW-1:0]     rd_addr;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	assign adv_sum = {1'b0, now_q} + {1'b0, item.time_value};
	assign adv_end = adv_sum[TIME_W] ? '1 : adv_sum[TIME_W-1:0];

	assign ins_ok = ((item.cmd == CMD_ADD) && (item.event_time >= now_q)) ||
		((item.cmd == CMD_LIST_ADD) && (item.event_time > now_q));
	assign full = (count_q == CW'(DEPTH));
	assign post_purge = (cmd_q == CMD_LIST_ADD) && lastl_q;

	assign idx_m1   = idx_q - CW'(1);
	assign ins_move = (cmd_q == CMD_ADD) ? (rd_time_q > et_q) : (rd_time_q >= et_q);

	assign compacts = (cmd_q == CMD_REMOVE) || (cmd_q == CMD_ADVANCE) ||
		(cmd_q == CMD_LIST_ADD);
	assign t_le = (rd_time_q <= lim_q);
	assign t_eq = (rd_time_q == lim_q);
	assign scan_end = (r_q == count_q);

	always_comb begin
		unique case (cmd_q)
			CMD_REMOVE:                scan_drop = t_eq;
			CMD_ADVANCE, CMD_LIST_ADD: scan_drop = t_le;
			default:                   scan_drop = 1'b0;
		endcase
	end

	always_comb begin
		unique case (cmd_q)
			CMD_ADVANCE:  scan_emit = t_le && (rd_time_q > now_q);
			CMD_DUMP_AT:  scan_emit = t_eq;
			CMD_DUMP_ALL: scan_emit = 1'b1;
			default:      scan_emit = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (item.cmd)
						CMD_ADD, CMD_LIST_ADD: begin
							if (ins_ok && !full) begin
								state_d = ST_INS_RD;
							end else if ((item.cmd == CMD_LIST_ADD) && item.last_of_list) begin
								state_d = ST_SCAN_RD;
							end else begin
								state_d = ST_FINISH;
							end
						end
						CMD_REMOVE, CMD_ADVANCE, CMD_DUMP_AT, CMD_DUMP_ALL: begin
							state_d = ST_SCAN_RD;
						end
						default: state_d = ST_FINISH;
					endcase
				end
			end
			ST_INS_RD: begin
				if (idx_q == '0) begin
					state_d = post_purge ? ST_SCAN_RD : ST_FINISH;
				end else begin
					state_d = ST_INS_EV;
				end
			end
			ST_INS_EV: begin
				if (ins_move) begin
					state_d = ST_INS_RD;
				end else begin
					state_d = post_purge ? ST_SCAN_RD : ST_FINISH;
				end
			end
			ST_SCAN_RD: state_d = scan_end ? ST_FINISH : ST_SCAN_EV;
			ST_SCAN_EV: state_d = ST_SCAN_RD;
			ST_FINISH:  state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = idx_q[AW-1:0];
		mem_wt  = et_q;
		mem_wid = eid_q;
		rd_addr = r_q[AW-1:0];
		res_stb = 1'b0;
		res     = pend_q;
		unique case (state_q)
			ST_INS_RD: begin
				rd_addr = idx_m1[AW-1:0];
				mem_we  = (idx_q == '0);
			end
			ST_INS_EV: begin
				mem_we = 1'b1;
				if (ins_move) begin
					mem_wt  = rd_time_q;
					mem_wid = rd_id_q;
				end
			end
			ST_SCAN_EV: begin
				mem_we  = compacts && !scan_drop;
				mem_wa  = w_q[AW-1:0];
				mem_wt  = rd_time_q;
				mem_wid = rd_id_q;
				res_stb = scan_emit && pend_vld_q;
				res.last = 1'b0;
			end
			ST_FINISH: begin
				res_stb = 1'b1;
				if (pend_vld_q) begin
					res.last = 1'b1;
				end else begin
					res = '{kind: KIND_ACK, out_time: '0, out_id: '0, last: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_time[mem_wa] <= mem_wt;
			mem_id[mem_wa]   <= mem_wid;
		end
		rd_time_q <= mem_time[rd_addr];
		rd_id_q   <= mem_id[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= item.cmd;
			et_q    <= item.event_time;
			eid_q   <= item.event_id[ID_W-1:0];
			lastl_q <= item.last_of_list;
			pend_q  <= '{kind: KIND_FULL, out_time: item.event_time,
				out_id: IN_ID_W'(item.event_id[ID_W-1:0]), last: 1'b0};
			if (item.cmd == CMD_ADVANCE) begin
				lim_q <= adv_end;
			end else if (item.cmd == CMD_LIST_ADD) begin
				lim_q <= now_q;
			end else begin
				lim_q <= item.time_value;
			end
		end else if ((state_q == ST_SCAN_EV) && scan_emit) begin
			pend_q <= '{kind: KIND_EVENT, out_time: rd_time_q,
				out_id: IN_ID_W'(rd_id_q), last: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			now_q      <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			r_q        <= '0;
			w_q        <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q      <= count_q;
						r_q        <= '0;
						w_q        <= '0;
						pend_vld_q <= ins_ok && full;
					end
				end
				ST_INS_RD: begin
					if (idx_q == '0) begin
						count_q <= count_q + CW'(1);
					end
				end
				ST_INS_EV: begin
					if (ins_move) begin
						idx_q <= idx_m1;
					end else begin
						count_q <= count_q + CW'(1);
					end
				end
				ST_SCAN_RD: begin
					if (scan_end && compacts) begin
						count_q <= w_q;
					end
				end
				ST_SCAN_EV: begin
					r_q <= r_q + CW'(1);
					if (compacts && !scan_drop) begin
						w_q <= w_q + CW'(1);
					end
					if (scan_emit) begin
						pend_vld_q <= 1'b1;
					end
				end
				ST_FINISH: begin
					if (cmd_q == CMD_ADVANCE) begin
						now_q <= lim_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
